// ===== rtl/surface_pixel_access_macros.svh =====
// assertion macros for the surface pixel access block
`ifndef SURFACE_PIXEL_ACCESS_MACROS_SVH
`define SURFACE_PIXEL_ACCESS_MACROS_SVH

// same-cycle implication, quiet during reset
`define SPA_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("surface pixel access assertion failed");

// next-cycle implication, quiet during reset
`define SPA_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("surface pixel access assertion failed");

// next-cycle implication, also checked through reset
`define SPA_ASSERT_NXT_ALL(lbl, clk, a, c) \
   lbl: assert property (@(posedge clk) (a) |=> (c)) \
      else $error("surface pixel access assertion failed");

`endif

// ===== rtl/spa_pkg.sv =====
package spa_pkg;

   localparam int STORE_BYTES = 65536;
   localparam int ADDR_W = $clog2(STORE_BYTES);

   localparam logic [2:0] REG_WIDTH   = 3'd0;
   localparam logic [2:0] REG_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_PITCH   = 3'd2;
   localparam logic [2:0] REG_DEPTH   = 3'd3;
   localparam logic [2:0] REG_MODE    = 3'd4;
   localparam logic [2:0] REG_MAXIMA  = 3'd5;
   localparam logic [2:0] REG_SHIFTS  = 3'd6;
   localparam logic [2:0] REG_PRESENT = 3'd7;

   typedef struct packed {
      logic       done;
      logic [7:0] quo;
   } div_res_type;

   // exact p/255 for any p up to 65279, where the quotient still fits in 8 bits
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] t;
      t = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

// ===== rtl/spa_ram.sv =====
module spa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/spa_div.sv =====
module spa_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [15:0]         num,
   input  logic [7:0]          den,
   output spa_pkg::div_res_type res
);

   logic        active_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [7:0]  rem_ff;
   logic [15:0] q_ff;
   logic [7:0]  den_ff;
   logic [8:0]  trial;
   logic        fits;

   assign trial = {rem_ff, q_ff[15]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            active_ff <= 1'b1;
            cnt_ff    <= 5'd16;
            rem_ff    <= '0;
            q_ff      <= num;
            den_ff    <= den;
         end else if (active_ff) begin
            rem_ff <= fits ? 8'(trial - {1'b0, den_ff}) : trial[7:0];
            q_ff   <= {q_ff[14:0], fits};
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   assign res.done = done_ff;
   assign res.quo  = q_ff[7:0];

endmodule

// ===== rtl/surface_pixel_access.sv =====
// channel    direction  handshake
// request    in         start high and busy low at the clock edge
// response   out        rsp_valid strobe, one cycle, always taken
// csr        in/out     apb write at psel, penable, pwrite, pready high
//
// after reset the store is swept to zero, one byte a cycle, with busy held high
// an outside request is answered in the next cycle and leaves busy low
// inside: a read and a capture state per byte read, a write state per byte written
// packed writes add a multiply and an accumulate state per channel
// packed reads use one 16-step divider shared by the channels
// the response cannot be stalled
module surface_pixel_access (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [15:0] req_x_coord,
   input  logic [15:0] req_y_coord,
   input  logic [31:0] req_pixel_value,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_value,
   output logic        rsp_inside_res,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = spa_pkg::ADDR_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ADDR, S_RD, S_CAP, S_ROUTE, S_PACK_MUL, S_PACK_ACC,
      S_WR, S_DIV_START, S_DIV_WAIT, S_DONE
   } state_type;

   typedef enum logic [1:0] {K_NONE, K_NIB, K_BYTES, K_PACKED} kind_type;

   state_type   state_ff;
   kind_type    kind_ff;

   logic [12:0] width_ff, height_ff;
   logic [15:0] pitch_ff;
   logic [2:0]  depth_ff, mode_ff;
   logic [31:0] max_ff;
   logic [19:0] shift_ff;
   logic [3:0]  pres_ff;

   logic          op_ff;
   logic [12:0]   x_ff;
   logic [31:0]   cval_ff, raw_ff, wval_ff, res_ff;
   logic [AW-1:0] prod_ff, addr_ff, clr_ff;
   logic [1:0]    n_ff, cnt_ff, k_ff;
   logic [15:0]   mul_ff;
   logic          rsp_valid_ff, rsp_inside_ff;
   logic [31:0]   rsp_value_ff;

   logic          csr_wr, in_bounds;
   logic [28:0]   pmul;
   logic [15:0]   xoff, cmul, num_k;
   logic [AW-1:0] byte_addr, ram_waddr;
   logic          ram_we;
   logic [7:0]    ram_wdata, ram_rdata, max_k, val_k, nib;
   logic [31:0]   raw_sh;
   logic [4:0]    sh_k;
   logic          pres_k, div_go, low;
   spa_pkg::div_res_type div_res;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         pitch_ff  <= '0;
         depth_ff  <= '0;
         mode_ff   <= '0;
         max_ff    <= '0;
         shift_ff  <= '0;
         pres_ff   <= '0;
      end else if (csr_wr) begin
         case (paddr[4:2])
            spa_pkg::REG_WIDTH:   width_ff  <= pwdata[12:0];
            spa_pkg::REG_HEIGHT:  height_ff <= pwdata[12:0];
            spa_pkg::REG_PITCH:   pitch_ff  <= pwdata[15:0];
            spa_pkg::REG_DEPTH:   depth_ff  <= pwdata[2:0];
            spa_pkg::REG_MODE:    mode_ff   <= pwdata[2:0];
            spa_pkg::REG_MAXIMA:  max_ff    <= pwdata;
            spa_pkg::REG_SHIFTS:  shift_ff  <= pwdata[19:0];
            spa_pkg::REG_PRESENT: pres_ff   <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         spa_pkg::REG_WIDTH:   prdata = {19'b0, width_ff};
         spa_pkg::REG_HEIGHT:  prdata = {19'b0, height_ff};
         spa_pkg::REG_PITCH:   prdata = {16'b0, pitch_ff};
         spa_pkg::REG_DEPTH:   prdata = {29'b0, depth_ff};
         spa_pkg::REG_MODE:    prdata = {29'b0, mode_ff};
         spa_pkg::REG_MAXIMA:  prdata = max_ff;
         spa_pkg::REG_SHIFTS:  prdata = {12'b0, shift_ff};
         spa_pkg::REG_PRESENT: prdata = {28'b0, pres_ff};
         default:              prdata = '0;
      endcase
   end

   assign in_bounds = !req_x_coord[15] && !req_y_coord[15]
                && (req_x_coord < {3'b0, width_ff}) && (req_y_coord < {3'b0, height_ff});
   assign pmul = pitch_ff * req_y_coord[12:0];
   assign xoff = (depth_ff == 3'd0) ? (mode_ff[2] ? {3'b0, x_ff} : {4'b0, x_ff[12:1]})
                                    : x_ff * depth_ff;

   assign max_k  = max_ff[{k_ff, 3'b000} +: 8];
   assign sh_k   = shift_ff[5*k_ff +: 5];
   assign pres_k = pres_ff[k_ff];
   assign raw_sh = raw_ff >> sh_k;
   assign val_k  = max_k & raw_sh[7:0];
   assign num_k  = {val_k, 8'b0} - {8'b0, val_k};
   assign cmul   = cval_ff[{k_ff, 3'b000} +: 8] * max_k;
   assign div_go = (state_ff == S_DIV_START) && pres_k && (max_k != 8'd0);
   assign low    = x_ff[0] ^ mode_ff[1];
   assign nib    = low ? {raw_ff[7:4], cval_ff[3:0]} : {cval_ff[3:0], raw_ff[3:0]};

   assign byte_addr = addr_ff + AW'(cnt_ff);
   assign ram_we    = (state_ff == S_CLEAR) || (state_ff == S_WR);
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_ff : byte_addr;
   assign ram_wdata = (state_ff == S_CLEAR) ? 8'd0 : wval_ff[{cnt_ff, 3'b000} +: 8];

   spa_ram #(.WIDTH(8), .DEPTH(spa_pkg::STORE_BYTES)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (byte_addr),
      .rdata (ram_rdata)
   );

   spa_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (num_k),
      .den   (max_k),
      .res   (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(spa_pkg::STORE_BYTES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  if (!in_bounds) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_value_ff  <= '0;
                     rsp_inside_ff <= 1'b0;
                  end else begin
                     op_ff    <= req_opcode;
                     x_ff     <= req_x_coord[12:0];
                     cval_ff  <= req_pixel_value;
                     prod_ff  <= AW'(pmul);
                     state_ff <= S_ADDR;
                  end
               end
            end
            S_ADDR: begin
               addr_ff <= prod_ff + AW'(xoff);
               res_ff  <= '0;
               raw_ff  <= '0;
               wval_ff <= '0;
               cnt_ff  <= '0;
               k_ff    <= '0;
               n_ff    <= 2'(depth_ff - 3'd1);
               if (mode_ff[0]) begin
                  if (depth_ff == 3'd0) begin
                     kind_ff  <= K_NIB;
                     n_ff     <= 2'd0;
                     state_ff <= S_RD;
                  end else if (depth_ff inside {3'd1, 3'd2, 3'd4}) begin
                     kind_ff <= K_BYTES;
                     if (op_ff) begin
                        wval_ff  <= cval_ff;
                        state_ff <= S_WR;
                     end else begin
                        state_ff <= S_RD;
                     end
                  end else begin
                     kind_ff  <= K_NONE;
                     state_ff <= S_DONE;
                  end
               end else if (depth_ff inside {[3'd2:3'd4]}) begin
                  kind_ff  <= K_PACKED;
                  state_ff <= op_ff ? S_PACK_MUL : S_RD;
               end else begin
                  kind_ff  <= K_NONE;
                  state_ff <= S_DONE;
               end
            end
            S_RD: begin
               state_ff <= S_CAP;
            end
            S_CAP: begin
               raw_ff[{cnt_ff, 3'b000} +: 8] <= ram_rdata;
               if (cnt_ff == n_ff) begin
                  state_ff <= S_ROUTE;
               end else begin
                  cnt_ff   <= cnt_ff + 2'd1;
                  state_ff <= S_RD;
               end
            end
            S_ROUTE: begin
               cnt_ff <= '0;
               case (kind_ff)
                  K_NIB: begin
                     if (op_ff) begin
                        wval_ff  <= {24'b0, mode_ff[2] ? cval_ff[7:0] : nib};
                        state_ff <= S_WR;
                     end else begin
                        if (mode_ff[2]) begin
                           res_ff <= {24'b0, raw_ff[7:0]};
                        end else begin
                           res_ff <= {28'b0, low ? raw_ff[3:0] : raw_ff[7:4]};
                        end
                        state_ff <= S_DONE;
                     end
                  end
                  K_PACKED: begin
                     state_ff <= S_DIV_START;
                  end
                  default: begin
                     res_ff   <= raw_ff;
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_PACK_MUL: begin
               mul_ff   <= cmul;
               state_ff <= S_PACK_ACC;
            end
            S_PACK_ACC: begin
               wval_ff <= wval_ff | (32'(spa_pkg::div255(mul_ff)) << sh_k);
               k_ff    <= k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  cnt_ff   <= '0;
                  state_ff <= S_WR;
               end else begin
                  state_ff <= S_PACK_MUL;
               end
            end
            S_WR: begin
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == n_ff) begin
                  state_ff <= S_DONE;
               end
            end
            S_DIV_START: begin
               if (!div_go) begin
                  res_ff[{k_ff, 3'b000} +: 8] <= (!pres_k && k_ff == 2'd3) ? 8'hFF : 8'd0;
                  k_ff <= k_ff + 2'd1;
                  if (k_ff == 2'd3) begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  state_ff <= S_DIV_WAIT;
               end
            end
            S_DIV_WAIT: begin
               if (div_res.done) begin
                  res_ff[{k_ff, 3'b000} +: 8] <= div_res.quo;
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= (k_ff == 2'd3) ? S_DONE : S_DIV_START;
               end
            end
            S_DONE: begin
               rsp_valid_ff  <= 1'b1;
               rsp_value_ff  <= op_ff ? 32'd0 : res_ff;
               rsp_inside_ff <= 1'b1;
               state_ff      <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy           = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule

// ===== rtl/spa_checker.sv =====
`include "surface_pixel_access_macros.svh"

module spa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_read_value,
   input logic        rsp_inside_res
);

   // every accepted request either answers at once or holds the block busy
   `SPA_ASSERT_NXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy)
   // a nonzero value only comes from inside the surface
   `SPA_ASSERT_IMP(a_value_inside, clock, reset, rsp_valid && rsp_read_value != 32'd0, rsp_inside_res)
   // the store clearing sweep follows reset
   `SPA_ASSERT_NXT_ALL(a_reset_clears, clock, reset, busy && !rsp_valid)

endmodule

bind surface_pixel_access spa_checker u_spa_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_read_value (rsp_read_value),
   .rsp_inside_res (rsp_inside_res)
);
